// ----- hw/rtl/sws_pkg.sv -----
`default_nettype none
package sws_pkg;

   localparam int WINDOW_DEPTH = 1024;
   localparam int ADDR_W = $clog2(WINDOW_DEPTH);
   localparam int CNT_W = ADDR_W + 1;

   // Register indexes on the configuration port.
   localparam logic CSR_WINDOW_TIME = 1'b0;
   localparam logic CSR_MAX_POINTS = 1'b1;

   // Operation codes.
   localparam logic FUNC_ADD = 1'b0;
   localparam logic FUNC_CLEAR = 1'b1;

   typedef struct packed {
      logic        func;
      logic [31:0] sample_value;
      logic [31:0] time_now;
   } req_type;

   typedef struct packed {
      logic [10:0] sample_count;
      logic [41:0] window_sum;
      logic [39:0] average_q8;
      logic [30:0] window_max;
      logic [31:0] window_min;
      logic        overflow_drop;
   } rsp_type;

endpackage
`default_nettype wire

// ----- hw/rtl/sws_divider.sv -----
`default_nettype none
// Restoring divider: magnitude of a 50-bit dividend over an 11-bit divisor,
// one quotient bit per cycle, sign restored at the end (truncation toward zero).
module sws_divider (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   input  wire logic [49:0] dividend,
   input  wire logic [10:0] divisor,
   output logic             done,
   output logic [39:0]      quotient
);

   logic [5:0]  step_ff, step_in;
   logic        busy_ff, busy_in;
   logic        neg_ff, neg_in;
   logic [49:0] quo_ff, quo_in;
   logic [11:0] rem_ff, rem_in;
   logic [10:0] den_ff, den_in;
   logic        done_ff, done_in;
   logic [11:0] trial;
   logic [49:0] magnitude;
   logic [49:0] signed_quo;

   assign magnitude = dividend[49] ? (~dividend + 50'd1) : dividend;
   assign trial = {rem_ff[10:0], quo_ff[49]};
   assign signed_quo = neg_ff ? (~quo_ff + 50'd1) : quo_ff;

   // One quotient bit per cycle.
   always_comb begin
      step_in = step_ff;
      busy_in = busy_ff;
      neg_in = neg_ff;
      quo_in = quo_ff;
      rem_in = rem_ff;
      den_in = den_ff;
      done_in = 1'b0;
      if (start) begin
         busy_in = 1'b1;
         step_in = 6'd0;
         neg_in = dividend[49];
         quo_in = magnitude;
         rem_in = 12'd0;
         den_in = divisor;
      end else if (busy_ff) begin
         if (trial >= {1'b0, den_ff}) begin
            rem_in = trial - {1'b0, den_ff};
            quo_in = {quo_ff[48:0], 1'b1};
         end else begin
            rem_in = trial;
            quo_in = {quo_ff[48:0], 1'b0};
         end
         step_in = step_ff + 6'd1;
         if (step_ff == 6'd49) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      step_ff <= step_in;
      neg_ff <= neg_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign done = done_ff;
   assign quotient = signed_quo[39:0];

endmodule
`default_nettype wire

// ----- hw/rtl/sliding_window_statistics.sv -----
`default_nettype none
// An accepted item first evicts the entries that are too old or over the point limit and is
// then appended; a clear empties the window instead. The sample and time memories are read
// entry by entry for eviction, with a read state and then a check state per entry, and are
// walked one entry per cycle for the min/max scan; then a one-bit-per-cycle divider forms
// the average. One item is in work at a time: the next item can be taken in the cycle after
// the result is accepted.
// Reset (synchronous) empties the window and loads the register defaults.
module sliding_window_statistics (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   input  wire sws_pkg::req_type     req_data,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   output sws_pkg::rsp_type          rsp_data,
   input  wire logic                 csr_write,
   input  wire logic                 csr_index,
   input  wire logic [30:0]          csr_wdata
);

   localparam int AW = sws_pkg::ADDR_W;
   localparam int CW = sws_pkg::CNT_W;

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_EREAD = 3'd1;
   localparam logic [2:0] ST_ECHECK = 3'd2;
   localparam logic [2:0] ST_SCAN = 3'd3;
   localparam logic [2:0] ST_DIV = 3'd4;
   localparam logic [2:0] ST_OUT = 3'd5;

   logic [2:0]  state_ff, state_in;
   logic [30:0] wtime_ff;
   logic [10:0] maxp_ff;
   logic [AW-1:0] oldest_ff, oldest_in;
   logic [CW-1:0] count_ff, count_in;
   logic [41:0] sum_ff, sum_in;
   sws_pkg::req_type req_ff, req_in;
   logic        drop_ff, drop_in;
   logic [CW-1:0] scan_ff, scan_in;
   logic        scan_rd_ff, scan_rd_in;
   logic signed [31:0] min_ff, min_in;
   logic signed [31:0] max_ff, max_in;
   logic        div_start;
   logic        div_done;
   logic [39:0] div_quo;
   sws_pkg::rsp_type rsp_ff, rsp_in;

   // Window memories: one read and one write port each.
   logic [31:0] sample_mem [sws_pkg::WINDOW_DEPTH];
   logic [31:0] time_mem [sws_pkg::WINDOW_DEPTH];
   logic [31:0] sample_rd_ff, time_rd_ff;
   logic [AW-1:0] rd_addr, wr_addr;
   logic        wr_en;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         sample_mem[wr_addr] <= req_ff.sample_value;
         time_mem[wr_addr] <= req_ff.time_now;
      end
      sample_rd_ff <= sample_mem[rd_addr];
      time_rd_ff <= time_mem[rd_addr];
   end

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         wtime_ff <= 31'h7FFFFFFF;
         maxp_ff <= 11'd0;
      end else if (csr_write) begin
         if (csr_index == sws_pkg::CSR_WINDOW_TIME) wtime_ff <= csr_wdata;
         else maxp_ff <= csr_wdata[10:0];
      end
   end

   logic signed [31:0] age;
   logic too_old, too_many;
   logic [AW-1:0] scan_addr;
   logic [AW-1:0] tail_addr;
   logic signed [31:0] rd_val;

   assign age = req_ff.time_now - time_rd_ff;
   assign too_old = age > $signed({1'b0, wtime_ff});
   assign too_many = (maxp_ff != 11'd0) && (CW'(maxp_ff) <= count_ff);
   assign scan_addr = oldest_ff + scan_ff[AW-1:0];
   assign tail_addr = oldest_ff + count_ff[AW-1:0];
   assign rd_val = sample_rd_ff;
   assign rd_addr = (state_ff == ST_SCAN) ? scan_addr : oldest_ff;

   // Sequencer: evict and append (or clear), scan, divide, present.
   always_comb begin
      state_in = state_ff;
      oldest_in = oldest_ff;
      count_in = count_ff;
      sum_in = sum_ff;
      req_in = req_ff;
      drop_in = drop_ff;
      scan_in = scan_ff;
      scan_rd_in = 1'b0;
      min_in = min_ff;
      max_in = max_ff;
      rsp_in = rsp_ff;
      wr_en = 1'b0;
      wr_addr = tail_addr;
      div_start = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               req_in = req_data;
               drop_in = 1'b0;
               if (req_data.func == sws_pkg::FUNC_CLEAR) begin
                  oldest_in = '0;
                  count_in = '0;
                  sum_in = '0;
                  scan_in = '0;
                  min_in = 32'sh7FFFFFFF;
                  max_in = '0;
                  state_in = ST_SCAN;
               end else begin
                  state_in = ST_EREAD;
               end
            end
         end
         ST_EREAD: begin
            state_in = ST_ECHECK;
         end
         ST_ECHECK: begin
            if (count_ff != '0 && (too_old || too_many)) begin
               sum_in = sum_ff - {{10{rd_val[31]}}, rd_val};
               oldest_in = oldest_ff + 1'b1;
               count_in = count_ff - 1'b1;
               state_in = ST_EREAD;
            end else begin
               // Append at the tail; a full store overwrites its oldest entry.
               wr_en = 1'b1;
               if (count_ff == CW'(sws_pkg::WINDOW_DEPTH)) begin
                  drop_in = 1'b1;
                  oldest_in = oldest_ff + 1'b1;
                  sum_in = sum_ff - {{10{rd_val[31]}}, rd_val}
                           + {{10{req_ff.sample_value[31]}}, req_ff.sample_value};
               end else begin
                  count_in = count_ff + 1'b1;
                  sum_in = sum_ff + {{10{req_ff.sample_value[31]}}, req_ff.sample_value};
               end
               scan_in = '0;
               min_in = 32'sh7FFFFFFF;
               max_in = '0;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (scan_rd_ff) begin
               if (rd_val > max_ff) max_in = rd_val;
               if (rd_val < min_in) min_in = rd_val;
            end
            if (scan_ff == count_ff) begin
               if (!scan_rd_ff) begin
                  div_start = 1'b1;
                  state_in = ST_DIV;
               end
            end else begin
               scan_in = scan_ff + 1'b1;
               scan_rd_in = 1'b1;
            end
         end
         ST_DIV: begin
            if (div_done) begin
               rsp_in.sample_count = 11'(count_ff);
               rsp_in.window_sum = sum_ff;
               rsp_in.average_q8 = (count_ff == '0) ? 40'd0 : div_quo;
               rsp_in.window_max = max_ff[30:0];
               rsp_in.window_min = (min_ff == 32'sh7FFFFFFF) ? 32'd0 : min_ff;
               rsp_in.overflow_drop = drop_ff;
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (rsp_ready) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         oldest_ff <= '0;
         count_ff <= '0;
         sum_ff <= '0;
         scan_rd_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         oldest_ff <= oldest_in;
         count_ff <= count_in;
         sum_ff <= sum_in;
         scan_rd_ff <= scan_rd_in;
      end
      req_ff <= req_in;
      drop_ff <= drop_in;
      scan_ff <= scan_in;
      min_ff <= min_in;
      max_ff <= max_in;
      rsp_ff <= rsp_in;
   end

   sws_divider u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend ({sum_ff, 8'd0}),
      .divisor  (11'(count_ff)),
      .done     (div_done),
      .quotient (div_quo)
   );

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = (state_ff == ST_OUT);
   assign rsp_data = rsp_ff;

`ifndef SYNTH
   // The window never holds more entries than the store.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(sws_pkg::WINDOW_DEPTH)) else $error("count beyond depth");
   // A result appears only after the divider finishes.
   a_out_after_div: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(div_done)) else $error("result without divide");
   // No item is taken while a result waits.
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid)) else $error("input open during output");
`endif

endmodule
`default_nettype wire
